>>> hw/rtl/gorc_pkg.sv
package gorc_pkg;

    // Fixed field widths.
    localparam int CNT_W  = 13;   // prefix entry and region count
    localparam int CRD_W  = 7;    // field size register and internal coordinates
    localparam int FLD_W  = 6;    // coordinate fields of an input word
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Default grid limits and register reset value.
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_RESET    = 64;

    // Last term index of the prefix gather for a load and for a query.
    localparam logic [1:0] LOAD_LAST_TERM  = 2'd2;
    localparam logic [1:0] QUERY_LAST_TERM = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_GATHER,
        ST_GATHER_END,
        ST_FINISH,
        ST_MV_SRC_RD,
        ST_MV_SRC_CHK,
        ST_MV_DST_RD,
        ST_MV_DST_CHK,
        ST_WALK
    } state_t;

    // Active field size, already clamped to the grid limits.
    typedef struct packed {
        logic [CRD_W-1:0] rows;
        logic [CRD_W-1:0] cols;
    } dims_t;

endpackage

>>> hw/rtl/grid_occupancy_range_count.sv
// A query gathers four prefix entries, then strobes its count; an empty rectangle
// skips the gather. A load gathers three entries and writes one. A clear zeroes all
// entries and cells. A move walks the prefix entries below and right of the source
// if it was occupied, then of the destination if it was empty. No word is taken
// while busy; the move walk over the single prefix memory port is the worst case.
// Results cannot be stalled. Reset: a clearing pass with busy high.
module grid_occupancy_range_count
    import gorc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [FLD_W-1:0]  row_a,
    input  logic [FLD_W-1:0]  col_a,
    input  logic [FLD_W-1:0]  row_b,
    input  logic [FLD_W-1:0]  col_b,
    input  logic              cell_value,
    output logic              result_valid,
    output logic [CNT_W-1:0]  region_count
);

    dims_t dims;

    // Field size registers.
    gorc_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // Memory sequencer.
    gorc_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .row_a        (row_a),
        .col_a        (col_a),
        .row_b        (row_b),
        .col_b        (col_b),
        .cell_value   (cell_value),
        .result_valid (result_valid),
        .region_count (region_count)
    );

endmodule

>>> hw/rtl/gorc_cfg.sv
module gorc_cfg
    import gorc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output dims_t             dims
);

    localparam int CRD_MAX = (1 << CRD_W) - 1;
    localparam int CAP_R   = (MAX_ROWS > CRD_MAX) ? CRD_MAX : MAX_ROWS;
    localparam int CAP_C   = (MAX_COLS > CRD_MAX) ? CRD_MAX : MAX_COLS;
    localparam int RST_R   = (CAP_R < CFG_RESET) ? CAP_R : CFG_RESET;
    localparam int RST_C   = (CAP_C < CFG_RESET) ? CAP_C : CFG_RESET;

    logic [CRD_W-1:0] rows_reg, rows_next;
    logic [CRD_W-1:0] cols_reg, cols_next;
    logic             wr_en;
    reg_idx_t         idx;

    // A zero size acts as one, a size above the grid acts as the grid.
    function automatic logic [CRD_W-1:0] clamp_dim(input logic [CRD_W-1:0] v,
                                                   input logic [CRD_W-1:0] cap);
        logic [CRD_W-1:0] res;
        if (v == '0)
        begin
            res = CRD_W'(1);
        end
        else if (v > cap)
        begin
            res = cap;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_AW-1]);

    // Register write decode.
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ROWS: rows_next = clamp_dim(pwdata[CRD_W-1:0], CRD_W'(CAP_R));
                REG_COLS: cols_next = clamp_dim(pwdata[CRD_W-1:0], CRD_W'(CAP_C));
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CRD_W'(RST_R);
            cols_reg <= CRD_W'(RST_C);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // Read-back of the active sizes.
    always_comb
    begin
        case (idx)
            REG_ROWS: prdata = APB_DW'(rows_reg);
            REG_COLS: prdata = APB_DW'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    assign dims.rows = rows_reg;
    assign dims.cols = cols_reg;

endmodule

>>> hw/rtl/gorc_seq.sv
module gorc_seq
    import gorc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dims_t            dims,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       operation,
    input  logic [FLD_W-1:0] row_a,
    input  logic [FLD_W-1:0] col_a,
    input  logic [FLD_W-1:0] row_b,
    input  logic [FLD_W-1:0] col_b,
    input  logic             cell_value,
    output logic             result_valid,
    output logic [CNT_W-1:0] region_count
);

    localparam int PSTRIDE = MAX_COLS + 1;
    localparam int PDEPTH  = (MAX_ROWS + 1) * PSTRIDE;
    localparam int GDEPTH  = MAX_ROWS * MAX_COLS;
    localparam int PA_W    = $clog2(PDEPTH);
    localparam int GA_W    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;

    // Storage: occupancy bits and prefix entries.
    logic             grid_mem   [GDEPTH];
    logic [CNT_W-1:0] prefix_mem [PDEPTH];

    logic             g_we, g_wd, grid_q;
    logic [GA_W-1:0]  g_wa, g_ra;
    logic             p_we;
    logic [PA_W-1:0]  p_wa, p_ra;
    logic [CNT_W-1:0] p_wd, prefix_q;

    state_t           state_reg, state_next;
    logic [PA_W-1:0]  clr_reg, clr_next;
    logic             pend_reg, pend_next;
    logic             wb_valid_reg, wb_valid_next;
    logic             result_valid_reg, result_valid_next;

    op_t              op_reg, op_next;
    logic [CRD_W-1:0] ra_reg, ra_next, ca_reg, ca_next;
    logic [CRD_W-1:0] rb_reg, rb_next, cb_reg, cb_next;
    logic             v_reg, v_next;
    logic [1:0]       term_reg, term_next, last_term_reg, last_term_next;
    logic             psub_reg, psub_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CRD_W-1:0] i_reg, i_next, j_reg, j_next, jstart_reg, jstart_next;
    logic             dec_reg, dec_next, walk_dst_reg, walk_dst_next;
    logic [PA_W-1:0]  wb_addr_reg, wb_addr_next;

    logic             accept;
    op_t              op_in;
    logic [CRD_W-1:0] ra_in, ca_in, rb_in, cb_in, rb_clamp, cb_clamp;
    logic             load_ok, move_ok, q_empty;
    logic [CRD_W-1:0] t_row, t_col;
    logic             t_sub;
    logic             clr_last, walk_last;

    function automatic logic [PA_W-1:0] pa_of(input logic [CRD_W-1:0] r,
                                              input logic [CRD_W-1:0] c);
        return PA_W'(r) * PA_W'(PSTRIDE) + PA_W'(c);
    endfunction

    function automatic logic [GA_W-1:0] ga_of(input logic [CRD_W-1:0] r,
                                              input logic [CRD_W-1:0] c);
        return GA_W'(r) * GA_W'(MAX_COLS) + GA_W'(c);
    endfunction

    // Synchronous memories, one read and one write port each.
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            grid_mem[g_wa] <= g_wd;
        end
        grid_q <= grid_mem[g_ra];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prefix_mem[p_wa] <= p_wd;
        end
        prefix_q <= prefix_mem[p_ra];
    end

    // Input word decode.
    assign busy     = (state_reg != ST_IDLE) || wb_valid_reg;
    assign accept   = start && !busy;
    assign op_in    = op_t'(operation);
    assign ra_in    = CRD_W'(row_a);
    assign ca_in    = CRD_W'(col_a);
    assign rb_in    = CRD_W'(row_b);
    assign cb_in    = CRD_W'(col_b);
    assign rb_clamp = (rb_in >= dims.rows) ? CRD_W'(dims.rows - 1'b1) : rb_in;
    assign cb_clamp = (cb_in >= dims.cols) ? CRD_W'(dims.cols - 1'b1) : cb_in;
    assign load_ok  = (ra_in < dims.rows) && (ca_in < dims.cols);
    assign move_ok  = load_ok && (rb_in < dims.rows) && (cb_in < dims.cols);
    assign q_empty  = (ra_in > rb_clamp) || (ca_in > cb_clamp);

    assign clr_last  = (clr_reg == PA_W'(PDEPTH - 1));
    assign walk_last = (i_reg == dims.rows) && (j_reg == dims.cols);

    // Prefix entry and sign of the current gather term.
    always_comb
    begin
        t_row = ra_reg;
        t_col = ca_reg;
        t_sub = 1'b0;
        if (op_reg == OP_LOAD)
        begin
            case (term_reg)
                2'd0:
                begin
                    t_col = CRD_W'(ca_reg + 1'b1);
                end
                2'd1:
                begin
                    t_row = CRD_W'(ra_reg + 1'b1);
                end
                default:
                begin
                    t_sub = 1'b1;
                end
            endcase
        end
        else
        begin
            case (term_reg)
                2'd0:
                begin
                    t_row = CRD_W'(rb_reg + 1'b1);
                    t_col = CRD_W'(cb_reg + 1'b1);
                end
                2'd1:
                begin
                    t_row = CRD_W'(rb_reg + 1'b1);
                    t_sub = 1'b1;
                end
                2'd2:
                begin
                    t_col = CRD_W'(cb_reg + 1'b1);
                    t_sub = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_LOAD:  state_next = load_ok ? ST_GATHER : ST_IDLE;
                        OP_MOVE:  state_next = move_ok ? ST_MV_SRC_RD : ST_IDLE;
                        OP_QUERY: state_next = q_empty ? ST_FINISH : ST_GATHER;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:      state_next = clr_last ? ST_IDLE : ST_CLEAR;
            ST_GATHER:     state_next = (term_reg == last_term_reg) ? ST_GATHER_END : ST_GATHER;
            ST_GATHER_END: state_next = ST_FINISH;
            ST_FINISH:     state_next = ST_IDLE;
            ST_MV_SRC_RD:  state_next = ST_MV_SRC_CHK;
            ST_MV_SRC_CHK: state_next = grid_q ? ST_WALK : ST_MV_DST_RD;
            ST_MV_DST_RD:  state_next = ST_MV_DST_CHK;
            ST_MV_DST_CHK: state_next = grid_q ? ST_IDLE : ST_WALK;
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = walk_dst_reg ? ST_IDLE : ST_MV_DST_RD;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Memory controls and datapath.
    always_comb
    begin
        g_we = 1'b0;
        g_wa = '0;
        g_wd = 1'b0;
        g_ra = '0;
        p_we = 1'b0;
        p_wa = '0;
        p_wd = '0;
        p_ra = '0;

        clr_next          = clr_reg;
        pend_next         = pend_reg;
        wb_valid_next     = 1'b0;
        result_valid_next = 1'b0;
        op_next           = op_reg;
        ra_next           = ra_reg;
        ca_next           = ca_reg;
        rb_next           = rb_reg;
        cb_next           = cb_reg;
        v_next            = v_reg;
        term_next         = term_reg;
        last_term_next    = last_term_reg;
        psub_next         = psub_reg;
        acc_next          = acc_reg;
        count_next        = count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        jstart_next       = jstart_reg;
        dec_next          = dec_reg;
        walk_dst_next     = walk_dst_reg;
        wb_addr_next      = wb_addr_reg;

        // Read data of the previous gather term arrives now.
        if (pend_reg)
        begin
            acc_next = psub_reg ? CNT_W'(acc_reg - prefix_q) : CNT_W'(acc_reg + prefix_q);
        end

        // Write-back of the entry read by the walk in the previous cycle.
        if (wb_valid_reg)
        begin
            p_we = 1'b1;
            p_wa = wb_addr_reg;
            p_wd = dec_reg ? CNT_W'(prefix_q - 1'b1) : CNT_W'(prefix_q + 1'b1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op_in;
                    ra_next        = ra_in;
                    ca_next        = ca_in;
                    rb_next        = (op_in == OP_QUERY) ? rb_clamp : rb_in;
                    cb_next        = (op_in == OP_QUERY) ? cb_clamp : cb_in;
                    v_next         = cell_value;
                    term_next      = '0;
                    pend_next      = 1'b0;
                    clr_next       = '0;
                    acc_next       = (op_in == OP_LOAD) ? CNT_W'(cell_value) : '0;
                    last_term_next = (op_in == OP_LOAD) ? LOAD_LAST_TERM : QUERY_LAST_TERM;
                end
            end
            ST_CLEAR:
            begin
                p_we     = 1'b1;
                p_wa     = clr_reg;
                p_wd     = '0;
                g_we     = (clr_reg < PA_W'(GDEPTH));
                g_wa     = GA_W'(clr_reg);
                g_wd     = 1'b0;
                clr_next = PA_W'(clr_reg + 1'b1);
            end
            ST_GATHER:
            begin
                p_ra      = pa_of(t_row, t_col);
                pend_next = 1'b1;
                psub_next = t_sub;
                term_next = 2'(term_reg + 1'b1);
            end
            ST_GATHER_END:
            begin
                pend_next = 1'b0;
            end
            ST_FINISH:
            begin
                if (op_reg == OP_LOAD)
                begin
                    p_we = 1'b1;
                    p_wa = pa_of(CRD_W'(ra_reg + 1'b1), CRD_W'(ca_reg + 1'b1));
                    p_wd = acc_reg;
                    g_we = 1'b1;
                    g_wa = ga_of(ra_reg, ca_reg);
                    g_wd = v_reg;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    count_next        = acc_reg;
                end
            end
            ST_MV_SRC_RD:
            begin
                g_ra = ga_of(ra_reg, ca_reg);
            end
            ST_MV_SRC_CHK:
            begin
                // Source cell empties: walk with -1 if it was occupied.
                g_we          = 1'b1;
                g_wa          = ga_of(ra_reg, ca_reg);
                g_wd          = 1'b0;
                i_next        = CRD_W'(ra_reg + 1'b1);
                j_next        = CRD_W'(ca_reg + 1'b1);
                jstart_next   = CRD_W'(ca_reg + 1'b1);
                dec_next      = 1'b1;
                walk_dst_next = 1'b0;
            end
            ST_MV_DST_RD:
            begin
                g_ra = ga_of(rb_reg, cb_reg);
            end
            ST_MV_DST_CHK:
            begin
                // Destination cell fills: walk with +1 if it was empty.
                g_we          = 1'b1;
                g_wa          = ga_of(rb_reg, cb_reg);
                g_wd          = 1'b1;
                i_next        = CRD_W'(rb_reg + 1'b1);
                j_next        = CRD_W'(cb_reg + 1'b1);
                jstart_next   = CRD_W'(cb_reg + 1'b1);
                dec_next      = 1'b0;
                walk_dst_next = 1'b1;
            end
            ST_WALK:
            begin
                p_ra          = pa_of(i_reg, j_reg);
                wb_valid_next = 1'b1;
                wb_addr_next  = pa_of(i_reg, j_reg);
                if (j_reg == dims.cols)
                begin
                    j_next = jstart_reg;
                    i_next = CRD_W'(i_reg + 1'b1);
                end
                else
                begin
                    j_next = CRD_W'(j_reg + 1'b1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            pend_reg         <= 1'b0;
            wb_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            pend_reg         <= pend_next;
            wb_valid_reg     <= wb_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ra_reg        <= ra_next;
        ca_reg        <= ca_next;
        rb_reg        <= rb_next;
        cb_reg        <= cb_next;
        v_reg         <= v_next;
        term_reg      <= term_next;
        last_term_reg <= last_term_next;
        psub_reg      <= psub_next;
        acc_reg       <= acc_next;
        count_reg     <= count_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        jstart_reg    <= jstart_next;
        dec_reg       <= dec_next;
        walk_dst_reg  <= walk_dst_next;
        wb_addr_reg   <= wb_addr_next;
    end

    assign result_valid = result_valid_reg;
    assign region_count = count_reg;

endmodule

>>> hw/rtl/gorc_checker.sv
module gorc_checker
    import gorc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       operation,
    input logic             result_valid,
    input logic [CNT_W-1:0] region_count
);

    // A result word never lasts more than one cycle.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // A result is only shown once the block has gone idle.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted query always shows busy in the cycle after it is taken.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_QUERY) |=> busy)
        else $error("query accepted without going busy");

    // Clear, load and move produce no result word.
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation != OP_QUERY) |=> !result_valid ##1 !result_valid)
        else $error("result word after a non-query operation");

    // The count travels with its strobe; it must be known when shown.
    a_count_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(region_count))
        else $error("unknown region count on result strobe");

endmodule

bind grid_occupancy_range_count gorc_checker u_gorc_checker (.*);

>>> bench/tb_grid_occupancy_range_count.sv
`timescale 1ns / 100ps

module tb_grid_occupancy_range_count;
    import gorc_pkg::*;

    // Longest quiet stretch of a correct block is a full move walk; the pause
    // after the last result covers it before the field size is changed.
    localparam int SETTLE_CYCLES  = 2 * DEF_MAX_ROWS * DEF_MAX_COLS + 16;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int WORD_TARGET    = 140;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_LOADS      = 16;

    // Occupancy grid, prefix table and field size as the block should hold
    // them, plus the region counts still owed by the block.
    class range_count_scoreboard;
        bit             grid [DEF_MAX_ROWS][DEF_MAX_COLS];
        bit [CNT_W-1:0] prefix [DEF_MAX_ROWS+1][DEF_MAX_COLS+1];
        int unsigned    rows = DEF_MAX_ROWS;
        int unsigned    cols = DEF_MAX_COLS;
        bit [CNT_W-1:0] pending_counts [$];
        int unsigned    mismatches = 0;

        function int unsigned clamp_size(logic [APB_DW-1:0] data, int unsigned limit);
            int unsigned v;
            v = int'(data[CRD_W-1:0]);
            if (v < 1) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void set_field_size(reg_idx_t idx, logic [APB_DW-1:0] data);
            if (idx == REG_ROWS)
                rows = clamp_size(data, DEF_MAX_ROWS);
            else
                cols = clamp_size(data, DEF_MAX_COLS);
        endfunction

        // A changed cell adds its change to every prefix entry below and right of it.
        function void write_cell(int r, int c, bit v);
            bit [CNT_W-1:0] delta;
            if (grid[r][c] == v) return;
            grid[r][c] = v;
            delta = v ? CNT_W'(1) : '1;
            for (int i = r + 1; i <= int'(rows); i++)
                for (int j = c + 1; j <= int'(cols); j++)
                    prefix[i][j] += delta;
        endfunction

        // Applies one accepted word; returns 1 unless the block ignores it.
        function bit apply_word(op_t op, logic [FLD_W-1:0] ra, logic [FLD_W-1:0] ca,
                                logic [FLD_W-1:0] rb, logic [FLD_W-1:0] cb, logic v);
            int             a;
            int             b;
            int             r1;
            int             c1;
            bit [CNT_W-1:0] sum;
            bit             effect;
            a = int'(ra);
            b = int'(ca);
            r1 = int'(rb);
            c1 = int'(cb);
            effect = 1'b1;
            case (op)
                OP_CLEAR:
                begin
                    foreach (grid[i, j]) grid[i][j] = 1'b0;
                    foreach (prefix[i, j]) prefix[i][j] = '0;
                end
                OP_LOAD:
                begin
                    // The entry is formed from its present neighbours, in order or not.
                    if (a >= int'(rows) || b >= int'(cols))
                        effect = 1'b0;
                    else
                    begin
                        grid[a][b] = v;
                        prefix[a+1][b+1] = CNT_W'(v) + prefix[a][b+1] + prefix[a+1][b]
                                         - prefix[a][b];
                    end
                end
                OP_MOVE:
                begin
                    if (a >= int'(rows) || b >= int'(cols) ||
                        r1 >= int'(rows) || c1 >= int'(cols))
                        effect = 1'b0;
                    else
                    begin
                        write_cell(a, b, 1'b0);
                        write_cell(r1, c1, 1'b1);
                    end
                end
                default:
                begin
                    // Bottom and right edges are clamped to the field first.
                    if (r1 >= int'(rows)) r1 = int'(rows) - 1;
                    if (c1 >= int'(cols)) c1 = int'(cols) - 1;
                    if (a > r1 || b > c1)
                        sum = '0;
                    else
                        sum = prefix[r1+1][c1+1] - prefix[r1+1][b] - prefix[a][c1+1]
                            + prefix[a][b];
                    pending_counts.push_back(sum);
                end
            endcase
            return effect;
        endfunction

        function void check_count(logic [CNT_W-1:0] actual);
            bit [CNT_W-1:0] want;
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word with nothing outstanding: region_count %0d", actual);
                return;
            end
            want = pending_counts.pop_front();
            if (actual !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("region_count mismatch: expected %0d, got %0d", want, actual);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [1:0]        operation;
    logic [FLD_W-1:0]  row_a;
    logic [FLD_W-1:0]  col_a;
    logic [FLD_W-1:0]  row_b;
    logic [FLD_W-1:0]  col_b;
    logic              cell_value;
    logic              result_valid;
    logic [CNT_W-1:0]  region_count;

    range_count_scoreboard sb;
    bit                    no_gaps;
    int unsigned           words_done;
    int unsigned           idle_cycles;

    grid_occupancy_range_count i_dut (.*);

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every region count that is strobed is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_count(region_count);
    end

    // Ends the run when nothing has moved for far longer than a correct block needs.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 || (psel && penable && pwrite))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [FLD_W-1:0] any_coord();
        return FLD_W'($urandom_range(0, (1 << FLD_W) - 1));
    endfunction

    // Mostly inside the field, now and then anywhere in the coordinate range.
    function automatic logic [FLD_W-1:0] pick_coord(int unsigned limit);
        if ($urandom_range(0, 4) == 0)
            return any_coord();
        return FLD_W'($urandom_range(0, limit - 1));
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    task automatic send_word(op_t op, logic [FLD_W-1:0] ra, logic [FLD_W-1:0] ca,
                             logic [FLD_W-1:0] rb, logic [FLD_W-1:0] cb, logic v);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        row_a      <= ra;
        col_a      <= ca;
        row_b      <= rb;
        col_b      <= cb;
        cell_value <= v;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        void'(sb.apply_word(op, ra, ca, rb, cb, v));
        words_done++;
    endtask

    task automatic wait_for_counts();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_counts.size() != 0) @(posedge clk);
    endtask

    // A move or clear yields no word, so allow its whole walk to finish as well.
    task automatic settle();
        wait_for_counts();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup then access phase; the unused upper data bits carry noise.
    task automatic write_reg(reg_idx_t idx, logic [CRD_W-1:0] size);
        logic [APB_DW-1:0] data;
        data = $urandom();
        data[CRD_W-1:0] = size;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        sb.set_field_size(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One field: settle, set the size, clear, row-major load with some stray loads,
    // then a mix of queries, moves, loads, clears and pauses that let the results drain.
    task automatic run_phase(logic [CRD_W-1:0] rows_w, logic [CRD_W-1:0] cols_w);
        int unsigned n_load;
        int unsigned n_ops;
        int unsigned sel;
        settle();
        write_reg(REG_ROWS, rows_w);
        write_reg(REG_COLS, cols_w);
        no_gaps = ($urandom_range(0, 3) == 0);
        send_word(OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                  1'($urandom_range(0, 1)));
        n_load = sb.rows * sb.cols;
        if (n_load > MAX_LOADS) n_load = MAX_LOADS;
        for (int k = 0; k < int'(n_load); k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(OP_LOAD, any_coord(), any_coord(), any_coord(), any_coord(),
                          1'($urandom_range(0, 1)));
            else
                send_word(OP_LOAD, FLD_W'(k / int'(sb.cols)), FLD_W'(k % int'(sb.cols)),
                          any_coord(), any_coord(), 1'($urandom_range(0, 1)));
        end
        n_ops = $urandom_range(10, 18);
        for (int k = 0; k < int'(n_ops); k++)
        begin
            sel = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
            if (sel < 8)
                send_word(OP_QUERY, pick_coord(sb.rows), pick_coord(sb.cols),
                          pick_coord(sb.rows), pick_coord(sb.cols), 1'($urandom_range(0, 1)));
            else if (sel < 15)
                send_word(OP_MOVE, pick_coord(sb.rows), pick_coord(sb.cols),
                          pick_coord(sb.rows), pick_coord(sb.cols), 1'($urandom_range(0, 1)));
            else if (sel < 18)
                send_word(OP_LOAD, pick_coord(sb.rows), pick_coord(sb.cols),
                          any_coord(), any_coord(), 1'($urandom_range(0, 1)));
            else if (sel == 18)
                wait_for_counts();
            else
                send_word(OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        operation   = OP_CLEAR;
        row_a       = '0;
        col_a       = '0;
        row_b       = '0;
        col_b       = '0;
        cell_value  = 1'b0;
        no_gaps     = 1'b0;
        words_done  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full 64 by 64 field from reset: empty grid, corner loads, a load out
        // of order, moves that wrap the table below zero, a move onto its own
        // source, empty rectangles and a clear.
        send_word(OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        send_word(OP_LOAD, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1);
        send_word(OP_LOAD, 6'd0, 6'd1, 6'd0, 6'd0, 1'b0);
        send_word(OP_LOAD, 6'd63, 6'd63, 6'd0, 6'd0, 1'b1);
        send_word(OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1);
        send_word(OP_MOVE, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        send_word(OP_MOVE, 6'd5, 6'd7, 6'd5, 6'd7, 1'b1);
        send_word(OP_QUERY, 6'd5, 6'd7, 6'd5, 6'd7, 1'b0);
        send_word(OP_QUERY, 6'd10, 6'd0, 6'd3, 6'd63, 1'b0);
        send_word(OP_QUERY, 6'd0, 6'd40, 6'd63, 6'd2, 1'b0);
        send_word(OP_QUERY, 6'd63, 6'd63, 6'd63, 6'd63, 1'b0);
        send_word(OP_LOAD, 6'd63, 6'd0, 6'd63, 6'd63, 1'b0);
        send_word(OP_LOAD, 6'd0, 6'd63, 6'd63, 6'd63, 1'b1);
        send_word(OP_QUERY, 6'd1, 6'd1, 6'd62, 6'd62, 1'b0);
        send_word(OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        send_word(OP_CLEAR, 6'd63, 6'd63, 6'd63, 6'd63, 1'b1);
        send_word(OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1);

        // Field sizes at and beyond the extremes, then small random fields.
        run_phase(7'd0, 7'd127);
        run_phase(7'd64, 7'd0);
        run_phase(7'd3, 7'd64);
        run_phase(7'd1, 7'd1);
        while (words_done < WORD_TARGET)
            run_phase(CRD_W'($urandom_range(1, 6)), CRD_W'($urandom_range(1, 6)));

        settle();
        if (sb.mismatches == 0 && sb.pending_counts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gorc_pkg.sv
hw/rtl/gorc_cfg.sv
hw/rtl/gorc_seq.sv
hw/rtl/grid_occupancy_range_count.sv
hw/rtl/gorc_checker.sv
bench/tb_grid_occupancy_range_count.sv
